[hdl/pas_pkg.sv]
// ----------------------------------------------------------------------------
// pas_pkg
// Types, field widths and codes shared by the preferential attachment sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package pas_pkg;

    localparam int REQ_W    = 2;
    localparam int RINT_W   = 31;
    localparam int FRAC_W   = 32;
    localparam int VIDX_W   = 18;
    localparam int DEG_W    = 22;
    localparam int SLOT_W   = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int EPV_W      = 4;
    localparam int SEED_W     = 7;
    localparam int NEWV_W     = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWV  = 2'd2;

    localparam logic [EPV_W-1:0]  EPV_RST  = 4'd5;
    localparam logic [SEED_W-1:0] SEED_RST = 7'd5;
    localparam logic [NEWV_W-1:0] NEWV_RST = 18'd150000;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [DEG_W-1:0] DEG_SAT = {DEG_W{1'b1}};

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_CAND = 2'd1;
    localparam logic [1:0] RD_NEW  = 2'd2;
    localparam logic [1:0] RD_IDX  = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [RINT_W-1:0] rnd_int;
        logic [FRAC_W-1:0] rnd_frac;
        logic [VIDX_W-1:0] vertex_index;
    } in_item_t;

    typedef struct packed {
        logic              accepted;
        logic [VIDX_W-1:0] chosen_vertex;
        logic [VIDX_W-1:0] new_vertex;
        logic [SLOT_W-1:0] edge_slot;
        logic              vertex_done;
        logic              graph_done;
        logic [DEG_W-1:0]  degree_value;
        logic [DEG_W-1:0]  max_degree;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic       clr_step;
        logic       seed_step;
        logic       draw_begin;
        logic       div_start;
        logic       cand_load;
        logic       mul_step;
        logic       bump_cand;
        logic       bump_new;
        logic       dval_load;
        logic       out_load;
        logic [1:0] rd_sel;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             draw_fin;
        logic             div_done;
        logic             clr_last;
        logic             seed_last;
        logic             draw_ok;
    } status_t;

endpackage

`default_nettype wire

[hdl/pas_modulo.sv]
// ----------------------------------------------------------------------------
// pas_modulo
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_modulo #(
    parameter int VW = 18
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [pas_pkg::RINT_W-1:0] dividend,
    input  wire logic [VW-1:0]             divisor,
    output logic                           done,
    output logic [VW-1:0]                  remainder
);

    localparam int CNT_W = $clog2(pas_pkg::RINT_W + 1);

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [VW-1:0]              rem_reg;
    logic [pas_pkg::RINT_W-1:0] dsh_reg;
    logic [VW-1:0]              div_reg;
    logic [VW:0]                trial;
    logic [VW:0]                diff;
    logic [VW-1:0]              rem_next;

    assign trial    = {rem_reg, dsh_reg[pas_pkg::RINT_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = (trial >= {1'b0, div_reg}) ? diff[VW-1:0] : trial[VW-1:0];

    assign done      = busy_reg && (cnt_reg == '0);
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(pas_pkg::RINT_W);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsh_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg && (cnt_reg != '0)) begin
            rem_reg <= rem_next;
            dsh_reg <= {dsh_reg[pas_pkg::RINT_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

[hdl/pas_datapath.sv]
// ----------------------------------------------------------------------------
// pas_datapath
// Degree memory, configuration, vertex state, acceptance test and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_datapath #(
    parameter int MAX_VERTICES = 262144,
    parameter int MAX_EDGES    = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pas_pkg::in_item_t            s_data,
    input  wire logic                         cfg_we,
    input  wire logic [pas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pas_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire pas_pkg::cmd_t                cmd,
    output pas_pkg::status_t                  sts,
    output pas_pkg::out_item_t                m_data
);

    localparam int VW       = $clog2(MAX_VERTICES);
    localparam int EW       = $clog2(MAX_EDGES + 1);
    localparam int SW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW       = ((VW > pas_pkg::NEWV_W) ? VW : pas_pkg::NEWV_W) + 2;
    localparam int PW       = pas_pkg::FRAC_W + pas_pkg::DEG_W;
    localparam int SEED_LIM = MAX_VERTICES / 2;

    function automatic logic [pas_pkg::DEG_W-1:0] deg_inc(input logic [pas_pkg::DEG_W-1:0] d);
        deg_inc = (d == pas_pkg::DEG_SAT) ? d : d + 1'b1;
    endfunction

    logic [pas_pkg::EPV_W-1:0]  epv_reg;
    logic [pas_pkg::SEED_W-1:0] seed_reg;
    logic [pas_pkg::NEWV_W-1:0] newv_reg;

    pas_pkg::in_item_t          in_reg;
    logic [VW-1:0]              cv_reg;
    logic [EW-1:0]              link_reg;
    logic [pas_pkg::DEG_W-1:0]  max_reg;
    logic                       fin_reg;
    logic [VW-1:0]              clr_cnt_reg;
    logic [EW-1:0]              seed_cnt_reg;
    logic [VW-1:0]              chosen_reg [MAX_EDGES];
    logic [VW-1:0]              cand_reg;
    logic [pas_pkg::DEG_W-1:0]  degc_reg;
    logic [PW-1:0]              prod_reg;
    logic                       acc_reg;
    logic [EW-1:0]              slot_reg;
    logic                       vdone_reg;
    logic [pas_pkg::DEG_W-1:0]  dval_reg;
    logic [pas_pkg::DEG_W-1:0]  rd_data_reg;
    pas_pkg::out_item_t         out_reg;

    logic [pas_pkg::DEG_W-1:0]  deg_mem [MAX_VERTICES];

    logic [CW-1:0]              s1, s_w, m1, m_lim, m_w, t1, t_lim, t_w, st_sum;
    logic [VW-1:0]              s_eff, t_eff, nv;
    logic [EW-1:0]              m_eff;
    logic [VW:0]                nv_wide;
    logic                       dup;
    logic                       mem_we;
    logic [VW-1:0]              mem_wa, mem_ra;
    logic [pas_pkg::DEG_W-1:0]  mem_wd;
    logic                       div_done;
    logic [VW-1:0]              div_rem;
    logic [EW-1:0]              link_inc;

    always_comb begin
        s1     = (seed_reg == '0) ? CW'(1) : CW'(seed_reg);
        s_w    = (s1 > CW'(SEED_LIM)) ? CW'(SEED_LIM) : s1;
        m1     = (epv_reg == '0) ? CW'(1) : CW'(epv_reg);
        m_lim  = (s_w < CW'(MAX_EDGES)) ? s_w : CW'(MAX_EDGES);
        m_w    = (m1 > m_lim) ? m_lim : m1;
        t1     = (newv_reg == '0) ? CW'(1) : CW'(newv_reg);
        t_lim  = CW'(MAX_VERTICES) - s_w;
        t_w    = (t1 > t_lim) ? t_lim : t1;
        st_sum = s_w + t_w;
        s_eff  = VW'(s_w);
        m_eff  = EW'(m_w);
        t_eff  = VW'(t_w);
    end

    assign nv_wide  = {1'b0, s_eff} + {1'b0, cv_reg};
    assign nv       = nv_wide[VW-1:0];
    assign link_inc = link_reg + 1'b1;

    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < MAX_EDGES; j++) begin
            if ((EW'(j) < link_reg) && (chosen_reg[SW'(j)] == cand_reg)) begin
                dup = 1'b1;
            end
        end
    end

    always_comb begin
        sts.req       = in_reg.req_type;
        sts.draw_fin  = fin_reg || (cv_reg >= t_eff);
        sts.div_done  = div_done;
        sts.clr_last  = (clr_cnt_reg == VW'(MAX_VERTICES - 1));
        sts.seed_last = (seed_cnt_reg == m_eff);
        sts.draw_ok   = (prod_reg < {degc_reg, {pas_pkg::FRAC_W{1'b0}}}) && !dup;
    end

    pas_modulo #(
        .VW (VW)
    ) u_modulo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (in_reg.rnd_int),
        .divisor   (nv),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        mem_we = cmd.clr_step | cmd.seed_step | cmd.bump_cand | cmd.bump_new;
        mem_wa = clr_cnt_reg;
        mem_wd = '0;
        if (cmd.seed_step) begin
            if (seed_cnt_reg < m_eff) begin
                mem_wa = VW'(seed_cnt_reg);
                mem_wd = pas_pkg::DEG_W'(1);
            end else begin
                mem_wa = s_eff;
                mem_wd = pas_pkg::DEG_W'(m_eff);
            end
        end else if (cmd.bump_cand) begin
            mem_wa = cand_reg;
            mem_wd = deg_inc(degc_reg);
        end else if (cmd.bump_new) begin
            mem_wa = nv;
            mem_wd = deg_inc(rd_data_reg);
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            pas_pkg::RD_CAND: mem_ra = cand_reg;
            pas_pkg::RD_NEW:  mem_ra = nv;
            pas_pkg::RD_IDX:  mem_ra = VW'(in_reg.vertex_index);
            default:          mem_ra = cand_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            deg_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= deg_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epv_reg      <= pas_pkg::EPV_RST;
            seed_reg     <= pas_pkg::SEED_RST;
            newv_reg     <= pas_pkg::NEWV_RST;
            cv_reg       <= VW'(1);
            link_reg     <= '0;
            max_reg      <= '0;
            fin_reg      <= 1'b0;
            clr_cnt_reg  <= '0;
            seed_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    pas_pkg::CFG_EDGES: epv_reg  <= cfg_data[pas_pkg::EPV_W-1:0];
                    pas_pkg::CFG_SEEDS: seed_reg <= cfg_data[pas_pkg::SEED_W-1:0];
                    pas_pkg::CFG_NEWV:  newv_reg <= cfg_data[pas_pkg::NEWV_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (cmd.seed_step) begin
                if (seed_cnt_reg < m_eff) begin
                    seed_cnt_reg <= seed_cnt_reg + 1'b1;
                end else begin
                    seed_cnt_reg <= '0;
                    max_reg      <= pas_pkg::DEG_W'(m_eff);
                    cv_reg       <= VW'(1);
                    link_reg     <= '0;
                    fin_reg      <= (t_eff <= VW'(1));
                end
            end
            if (cmd.draw_begin) begin
                if (cv_reg >= t_eff) begin
                    fin_reg <= 1'b1;
                end
                if (link_reg >= m_eff) begin
                    link_reg <= '0;
                end
            end
            if ((cmd.bump_cand || cmd.bump_new) && (mem_wd > max_reg)) begin
                max_reg <= mem_wd;
            end
            if (cmd.bump_new) begin
                if (link_inc >= m_eff) begin
                    link_reg <= '0;
                    cv_reg   <= cv_reg + 1'b1;
                    if ((cv_reg + 1'b1) >= t_eff) begin
                        fin_reg <= 1'b1;
                    end
                end else begin
                    link_reg <= link_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg    <= s_data;
            acc_reg   <= 1'b0;
            cand_reg  <= '0;
            slot_reg  <= '0;
            vdone_reg <= 1'b0;
            dval_reg  <= '0;
        end
        if (cmd.seed_step && (seed_cnt_reg < m_eff)) begin
            chosen_reg[seed_cnt_reg[SW-1:0]] <= VW'(seed_cnt_reg);
        end
        if (cmd.cand_load) begin
            cand_reg <= div_rem;
        end
        if (cmd.mul_step) begin
            prod_reg <= PW'(in_reg.rnd_frac) * PW'(max_reg);
            degc_reg <= rd_data_reg;
        end
        if (cmd.bump_cand) begin
            chosen_reg[link_reg[SW-1:0]] <= cand_reg;
        end
        if (cmd.bump_new) begin
            acc_reg   <= 1'b1;
            slot_reg  <= link_reg;
            vdone_reg <= (link_inc >= m_eff);
        end
        if (cmd.dval_load) begin
            dval_reg <= ({{(CW - pas_pkg::VIDX_W){1'b0}}, in_reg.vertex_index} < st_sum)
                        ? rd_data_reg : '0;
        end
        if (cmd.out_load) begin
            out_reg.accepted      <= acc_reg;
            out_reg.chosen_vertex <= pas_pkg::VIDX_W'(cand_reg);
            out_reg.new_vertex    <= pas_pkg::VIDX_W'(nv_wide);
            out_reg.edge_slot     <= pas_pkg::SLOT_W'(slot_reg);
            out_reg.vertex_done   <= vdone_reg;
            out_reg.graph_done    <= fin_reg;
            out_reg.degree_value  <= dval_reg;
            out_reg.max_degree    <= max_reg;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

[hdl/pas_ctrl.sv]
// ----------------------------------------------------------------------------
// pas_ctrl
// Sequencer: clearing pass, seeding, draw steps, degree reads, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire pas_pkg::status_t sts,
    output pas_pkg::cmd_t         cmd
);

    localparam logic [3:0] ST_RCLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_SCLEAR   = 4'd3;
    localparam logic [3:0] ST_SEED     = 4'd4;
    localparam logic [3:0] ST_DIV      = 4'd5;
    localparam logic [3:0] ST_RD1      = 4'd6;
    localparam logic [3:0] ST_MUL      = 4'd7;
    localparam logic [3:0] ST_TEST     = 4'd8;
    localparam logic [3:0] ST_BUMP2    = 4'd9;
    localparam logic [3:0] ST_RDWAIT   = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_RCLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.req)
                    pas_pkg::REQ_START: state_next = ST_SCLEAR;
                    pas_pkg::REQ_DRAW: begin
                        cmd.draw_begin = 1'b1;
                        if (sts.draw_fin) begin
                            state_next = ST_OUT;
                        end else begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    pas_pkg::REQ_READ: begin
                        cmd.rd_sel = pas_pkg::RD_IDX;
                        state_next = ST_RDWAIT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_SCLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                cmd.seed_step = 1'b1;
                if (sts.seed_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.cand_load = 1'b1;
                    state_next    = ST_RD1;
                end
            end
            ST_RD1: begin
                cmd.rd_sel = pas_pkg::RD_CAND;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST: begin
                if (sts.draw_ok) begin
                    cmd.bump_cand = 1'b1;
                    cmd.rd_sel    = pas_pkg::RD_NEW;
                    state_next    = ST_BUMP2;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_BUMP2: begin
                cmd.bump_new = 1'b1;
                state_next   = ST_OUT;
            end
            ST_RDWAIT: begin
                cmd.dval_load = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RCLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/preferential_attachment_sampler_top.sv]
// ----------------------------------------------------------------------------
// preferential_attachment_sampler_top
// Barabasi-Albert growth by rejection sampling over an on-chip degree memory.
// ----------------------------------------------------------------------------
// Draw: a 31-step remainder, a read of the candidate's degree, the product and the acceptance test.
// An ignored draw or an unknown request goes straight to the result; a degree read waits on the memory read port.
// Start: a clearing pass over all MAX_VERTICES entries, one memory entry cleared per cycle, then seeding.
// One transaction at a time; the result register lets the next one enter early.
// Reset: synchronous active low; a clearing pass over all MAX_VERTICES entries follows,
// with s_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module preferential_attachment_sampler_top #(
    parameter int MAX_VERTICES = 262144,
    parameter int MAX_EDGES    = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire pas_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output pas_pkg::out_item_t                  m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pas_pkg::CFG_DATA_W-1:0] cfg_data
);

    pas_pkg::cmd_t    cmd;
    pas_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    pas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pas_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

[hdl/pas_checker.sv]
// ----------------------------------------------------------------------------
// pas_checker
// Port-level checks on the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pas_pkg::out_item_t m_data
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in progress");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_done_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.vertex_done |-> m_data.accepted)
        else $error("vertex completed without an accepted link");

    a_accept_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> (m_data.max_degree != '0) &&
                                        (m_data.degree_value == '0))
        else $error("accepted link with zero maximum or a degree value");

endmodule

bind preferential_attachment_sampler_top pas_checker u_pas_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[verif/preferential_attachment_sampler_top_tb.sv]
// ----------------------------------------------------------------------------
// preferential_attachment_sampler_top_tb
// Self-checking bench for the preferential attachment sampler. Requests are
// queued by a sequencer, driven on the falling edge and predicted on
// acceptance by a behavioural model of the degree memory. Results are checked
// field by field in order. The run covers draws before any start, a start
// with a single new vertex, a full start, and four random-traffic phases with
// register changes between them. It ends by shrinking the graph so that the
// block reports completion.
// ----------------------------------------------------------------------------
`default_nettype none

module preferential_attachment_sampler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_VERT     = 262144;
    localparam int unsigned N_EDGE     = 8;
    localparam int unsigned HALF_CLK   = 6;
    localparam int unsigned QUIET_MAX  = 1 << 20;
    localparam int unsigned DRAIN_WAIT = 40;
    localparam int unsigned PHASE_LEN  = 455;

    localparam logic [pas_pkg::REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [pas_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    pas_pkg::in_item_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    pas_pkg::out_item_t             m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pas_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // model state
    logic [pas_pkg::DEG_W-1:0]  degree_mem [N_VERT];
    logic [pas_pkg::VIDX_W-1:0] picked_targets [N_EDGE];
    int unsigned                cur_vertex  = 1;
    int unsigned                links_done  = 0;
    logic [pas_pkg::DEG_W-1:0]  peak_degree = '0;
    logic                       graph_full  = 1'b0;
    logic [pas_pkg::EPV_W-1:0]  reg_edges   = pas_pkg::EPV_RST;
    logic [pas_pkg::SEED_W-1:0] reg_seeds   = pas_pkg::SEED_RST;
    logic [pas_pkg::NEWV_W-1:0] reg_newv    = pas_pkg::NEWV_RST;

    pas_pkg::in_item_t  queued_requests [$];
    pas_pkg::out_item_t awaited_outcomes [$];
    int unsigned n_queued = 0, n_taken = 0, n_results = 0, n_mismatch = 0;
    int unsigned n_draws = 0, n_links = 0, n_attached = 0, n_reads = 0, n_misc = 0;
    int unsigned send_gap_pct = 0, sink_stall_pct = 0, quiet_cycles = 0;
    bit          req_taken = 1'b0;

    preferential_attachment_sampler_top #(
        .MAX_VERTICES(N_VERT),
        .MAX_EDGES   (N_EDGE)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(HALF_CLK) aclk = ~aclk;

    function automatic void clear_degrees();
        for (int unsigned v = 0; v < N_VERT; v++) degree_mem[pas_pkg::VIDX_W'(v)] = '0;
    endfunction

    function automatic int unsigned seed_count();
        int unsigned s;
        s = 32'(reg_seeds);
        if (s < 1) s = 1;
        if (s > N_VERT / 2) s = N_VERT / 2;
        return s;
    endfunction

    function automatic void raise_degree(int unsigned v);
        logic [pas_pkg::VIDX_W-1:0] a;
        a = pas_pkg::VIDX_W'(v);
        if (degree_mem[a] != pas_pkg::DEG_SAT) degree_mem[a] = degree_mem[a] + 1'b1;
        if (degree_mem[a] > peak_degree) peak_degree = degree_mem[a];
    endfunction

    function automatic pas_pkg::out_item_t predict_attachment(pas_pkg::in_item_t req);
        int unsigned        s, m, t, lim, nv, cand, j;
        logic               ok;
        longint unsigned    lhs, rhs;
        pas_pkg::out_item_t res;
        res = '0;
        s = seed_count();
        lim = (N_EDGE < s) ? N_EDGE : s;
        m = 32'(reg_edges);
        if (m < 1) m = 1;
        if (m > lim) m = lim;
        t = 32'(reg_newv);
        if (t < 1) t = 1;
        if (t > N_VERT - s) t = N_VERT - s;
        case (req.req_type)
            pas_pkg::REQ_START: begin
                n_misc++;
                clear_degrees();
                for (j = 0; j < m; j++) begin
                    picked_targets[pas_pkg::SLOT_W'(j)] = pas_pkg::VIDX_W'(j);
                    degree_mem[pas_pkg::VIDX_W'(j)] = pas_pkg::DEG_W'(1);
                end
                degree_mem[pas_pkg::VIDX_W'(s)] = pas_pkg::DEG_W'(m);
                peak_degree = pas_pkg::DEG_W'(m);
                cur_vertex = 1;
                links_done = 0;
                graph_full = (t <= 1);
            end
            pas_pkg::REQ_DRAW: begin
                n_draws++;
                if (!graph_full && cur_vertex >= t) graph_full = 1'b1;
                if (!graph_full) begin
                    nv = s + cur_vertex;
                    if (links_done >= m) links_done = 0;
                    cand = req.rnd_int % nv;
                    res.chosen_vertex = pas_pkg::VIDX_W'(cand);
                    lhs = 64'(req.rnd_frac) * 64'(peak_degree);
                    rhs = 64'(degree_mem[pas_pkg::VIDX_W'(cand)]) << 32;
                    ok = (lhs < rhs);
                    for (j = 0; ok && j < links_done; j++)
                        if (picked_targets[pas_pkg::SLOT_W'(j)] == pas_pkg::VIDX_W'(cand))
                            ok = 1'b0;
                    if (ok) begin
                        n_links++;
                        res.accepted = 1'b1;
                        res.edge_slot = pas_pkg::SLOT_W'(links_done);
                        picked_targets[pas_pkg::SLOT_W'(links_done)] = pas_pkg::VIDX_W'(cand);
                        raise_degree(cand);
                        raise_degree(nv);
                        links_done++;
                        if (links_done >= m) begin
                            n_attached++;
                            res.vertex_done = 1'b1;
                            links_done = 0;
                            cur_vertex++;
                            if (cur_vertex >= t) graph_full = 1'b1;
                        end
                    end
                end
            end
            pas_pkg::REQ_READ: begin
                n_reads++;
                if (req.vertex_index < s + t)
                    res.degree_value = degree_mem[req.vertex_index];
            end
            default: n_misc++;
        endcase
        res.new_vertex = pas_pkg::VIDX_W'(s + cur_vertex);
        res.graph_done = graph_full;
        res.max_degree = peak_degree;
        return res;
    endfunction

    function automatic string describe(pas_pkg::out_item_t r);
        return $sformatf("acc %0d cand %0d new %0d slot %0d vdone %0d gdone %0d deg %0d max %0d",
                         r.accepted, r.chosen_vertex, r.new_vertex, r.edge_slot,
                         r.vertex_done, r.graph_done, r.degree_value, r.max_degree);
    endfunction

    task automatic queue_request(input logic [pas_pkg::REQ_W-1:0] rq,
                                 input logic [pas_pkg::RINT_W-1:0] ri,
                                 input logic [pas_pkg::FRAC_W-1:0] fr,
                                 input logic [pas_pkg::VIDX_W-1:0] vi);
        pas_pkg::in_item_t req;
        req.req_type     = rq;
        req.rnd_int      = ri;
        req.rnd_frac     = fr;
        req.vertex_index = vi;
        queued_requests.push_back(req);
        n_queued++;
    endtask

    task automatic write_reg(input logic [pas_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pas_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pas_pkg::CFG_EDGES: reg_edges = val[pas_pkg::EPV_W-1:0];
            pas_pkg::CFG_SEEDS: reg_seeds = val[pas_pkg::SEED_W-1:0];
            pas_pkg::CFG_NEWV:  reg_newv  = val[pas_pkg::NEWV_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge aclk); while (n_taken != n_queued || awaited_outcomes.size() != 0);
        @(posedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                s_data  <= queued_requests.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin : handshakes
        pas_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (awaited_outcomes.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result: %s", describe(m_data));
            end else begin
                want = awaited_outcomes.pop_front();
                if (m_data.accepted !== want.accepted
                        || m_data.chosen_vertex !== want.chosen_vertex
                        || m_data.new_vertex !== want.new_vertex
                        || m_data.edge_slot !== want.edge_slot
                        || m_data.vertex_done !== want.vertex_done
                        || m_data.graph_done !== want.graph_done
                        || m_data.degree_value !== want.degree_value
                        || m_data.max_degree !== want.max_degree) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result %0d differs", n_results);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(m_data));
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            awaited_outcomes.push_back(predict_attachment(s_data));
            n_taken++;
            req_taken = 1'b1;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("preferential_attachment_sampler_top: mismatch");
                $finish;
            end
        end
    end

    // sequencer
    initial begin
        int unsigned                    ph, k, pick;
        logic [pas_pkg::CFG_DATA_W-1:0] noise;
        clear_degrees();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, no start yet: nothing can be accepted
        queue_request(pas_pkg::REQ_DRAW, 31'h7FFF_FFFF, 32'h0000_0000, 18'h00000);
        queue_request(pas_pkg::REQ_DRAW, 31'h0000_0000, 32'hFFFF_FFFF, 18'h3FFFF);
        queue_request(pas_pkg::REQ_READ, 31'h0000_0000, 32'h0000_0000, 18'h00000);
        queue_request(pas_pkg::REQ_READ, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 18'h3FFFF);
        queue_request(REQ_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 18'h3FFFF);
        drain();

        // single new vertex: complete straight after the start
        write_reg(pas_pkg::CFG_NEWV, 18'd1);
        @(posedge aclk);
        queue_request(pas_pkg::REQ_START, 31'h0, 32'h0, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'h0, 32'h0, 18'h0);
        queue_request(pas_pkg::REQ_READ, 31'h0, 32'h0, 18'd5);
        drain();

        // full start, then accept, duplicate, zero degree and high fraction cases
        write_reg(pas_pkg::CFG_EDGES, 18'd3);
        write_reg(pas_pkg::CFG_SEEDS, 18'd4);
        write_reg(pas_pkg::CFG_NEWV, 18'h3FFFF);
        @(posedge aclk);
        queue_request(pas_pkg::REQ_START, 31'h0, 32'h0, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'd0, 32'h0000_0000, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'd0, 32'h0000_0000, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'd4, 32'h0000_0000, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'd3, 32'h0000_0000, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'd1, 32'hFFFF_FFFF, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'd2, 32'h0000_0000, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 18'h0);
        queue_request(pas_pkg::REQ_DRAW, 31'h7FFF_FFFF, 32'h0000_0000, 18'h0);
        queue_request(pas_pkg::REQ_READ, 31'h0, 32'h0, 18'd0);
        queue_request(pas_pkg::REQ_READ, 31'h0, 32'h0, 18'd4);
        queue_request(pas_pkg::REQ_READ, 31'h0, 32'h0, 18'd5);
        queue_request(pas_pkg::REQ_READ, 31'h0, 32'h0, 18'h3FFFF);
        queue_request(REQ_UNUSED, 31'h0, 32'h0, 18'h0);
        drain();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_gap_pct = 81;
                    sink_stall_pct = 0;
                    noise = pas_pkg::CFG_DATA_W'($urandom);
                    write_reg(pas_pkg::CFG_EDGES, noise | 18'h0000F);
                    noise = pas_pkg::CFG_DATA_W'($urandom);
                    write_reg(pas_pkg::CFG_SEEDS, (noise & ~18'h0007F) | 18'd64);
                end
                2: begin
                    send_gap_pct = 0;
                    sink_stall_pct = 81;
                    write_reg(pas_pkg::CFG_EDGES, 18'd0);
                    write_reg(pas_pkg::CFG_SEEDS, 18'd0);
                end
                default: begin
                    send_gap_pct = 25;
                    sink_stall_pct = 25;
                    write_reg(pas_pkg::CFG_EDGES, 18'd5);
                    write_reg(pas_pkg::CFG_SEEDS, 18'd127);
                    write_reg(CFG_SPARE, 18'h3FFFF);
                end
            endcase
            @(posedge aclk);
            for (k = 0; k < PHASE_LEN; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                    queue_request(pas_pkg::REQ_DRAW, pas_pkg::RINT_W'($urandom),
                                  ($urandom_range(0, 99) < 40) ?
                                      ($urandom >> $urandom_range(4, 31)) : $urandom,
                                  pas_pkg::VIDX_W'($urandom));
                else if (pick < 97)
                    queue_request(pas_pkg::REQ_READ, pas_pkg::RINT_W'($urandom), $urandom,
                                  pas_pkg::VIDX_W'(($urandom_range(0, 3) == 0) ? $urandom :
                                      $urandom_range(0, seed_count() + cur_vertex + 3)));
                else
                    queue_request(REQ_UNUSED, pas_pkg::RINT_W'($urandom), $urandom,
                                  pas_pkg::VIDX_W'($urandom));
            end
            drain();
        end

        // shrink the graph below its current size: draws now report completion
        write_reg(pas_pkg::CFG_NEWV, 18'd0);
        @(posedge aclk);
        queue_request(pas_pkg::REQ_DRAW, pas_pkg::RINT_W'($urandom), 32'h0,
                      pas_pkg::VIDX_W'($urandom));
        queue_request(pas_pkg::REQ_DRAW, pas_pkg::RINT_W'($urandom), $urandom,
                      pas_pkg::VIDX_W'($urandom));
        queue_request(pas_pkg::REQ_READ, pas_pkg::RINT_W'($urandom), $urandom, 18'd0);
        queue_request(pas_pkg::REQ_READ, pas_pkg::RINT_W'($urandom), $urandom,
                      pas_pkg::VIDX_W'($urandom));
        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d transactions: %0d draws giving %0d links over %0d vertices,",
                 n_taken, n_draws, n_links, n_attached);
        $display("  %0d degree reads, %0d starts and unknown requests, %0d mismatches",
                 n_reads, n_misc, n_mismatch);
        if (n_mismatch == 0 && awaited_outcomes.size() == 0) begin
            $display("preferential_attachment_sampler_top: match");
        end else begin
            $display("preferential_attachment_sampler_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
